>>> rtl/box_blur_3x3_edge_aware_defines.svh
// Assertion macros shared by the box blur RTL files.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH

`ifndef SYNTHESIS
`define BB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("box blur check failed");
`define BB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("box blur check failed");
`else
`define BB_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/bb3ea_pkg.sv
// Package: types, constants and divide helpers for the box blur.
`timescale 1ns / 1ps
`default_nettype none
package bb3ea_pkg;

	localparam int MAX_WIDTH_DEF  = 512;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int PIX_W        = 8;
	localparam int PIX_BITS     = 3 * PIX_W;
	localparam int WIDTH_REG_W  = 10;
	localparam int HEIGHT_REG_W = 13;
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 10'd512;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd512;

	// register index, taken from paddr[2]
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam int SUM_W       = 12;
	localparam int CNT_W       = 4;
	localparam int RECIP_W     = 19;
	localparam int RECIP_SHIFT = 18;
	localparam int MUL_W       = SUM_W + RECIP_W;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} pix_t;

	typedef struct packed {
		logic take;
		logic shift;
		logic sum;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic received;
		logic emit;
		logic out_busy;
	} stat_t;

	// ceil(2^18 / n); exact for biased sums up to 2299
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			4'd1: r = 19'd262144;
			4'd2: r = 19'd131072;
			4'd3: r = 19'd87382;
			4'd4: r = 19'd65536;
			4'd6: r = 19'd43691;
			4'd9: r = 19'd29128;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] chan_mean(input logic [SUM_W-1:0] sum,
			input logic [CNT_W-1:0] n);
		logic [SUM_W-1:0] biased;
		logic [MUL_W-1:0] prod;
		biased = sum + SUM_W'(n >> 1);
		prod = MUL_W'(biased) * MUL_W'(recip(n));
		return prod[RECIP_SHIFT +: PIX_W];
	endfunction

endpackage
`default_nettype wire

>>> rtl/bb3ea_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bb3ea_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/bb3ea_ctrl.sv
// Controller state machine for the box blur.
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_3x3_edge_aware_defines.svh"
module bb3ea_ctrl
	import bb3ea_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	input  wire logic  s_action,
	output logic       s_tready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SHIFT = 5'b00010,
		ST_READ  = 5'b00100,
		ST_SUM   = 5'b01000,
		ST_MUL   = 5'b10000
	} state_t;

	state_t st_q, st_d;
	logic   accept;

	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		st_d         = st_q;
		cmd          = '0;
		cmd.take     = accept && (stat.received || !s_action);
		case (st_q)
			ST_IDLE: begin
				if (cmd.take) begin
					st_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (stat.emit) begin
					st_d = ST_SUM;
				end else if (stat.received) begin
					st_d = ST_READ;
				end else begin
					st_d = ST_IDLE;
				end
			end
			ST_READ: begin
				st_d = ST_SHIFT;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				st_d    = ST_MUL;
			end
			ST_MUL: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					st_d         = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	`BB_ASSERT_NOW(a_load_free, clk, arst_n, cmd.load_out, !stat.out_busy)
	`BB_ASSERT_NOW(a_read_drain, clk, arst_n, st_q == ST_READ, stat.received)

endmodule
`default_nettype wire

>>> rtl/bb3ea_dp.sv
// Datapath: line stores, 3x3 window, frame counters, sums and rounding divide.
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_3x3_edge_aware_defines.svh"
module bb3ea_dp
	import bb3ea_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [WIDTH_REG_W-1:0]  eff_w,
	input  wire logic [HEIGHT_REG_W-1:0] eff_h,
	input  wire logic                    cfg_clear,
	input  wire logic [PIX_BITS-1:0]     s_tdata,
	input  wire cmd_t                    cmd,
	output stat_t                        stat,
	input  wire logic                    m_tready,
	output logic                         m_tvalid,
	output logic [PIX_BITS-1:0]          m_tdata,
	output logic                         m_tlast
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int DW = $clog2(MAX_WIDTH + 2);

	logic [CW-1:0] w_last;
	logic [RW-1:0] h_last;
	logic [DW-1:0] d_target;

	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [DW-1:0] d_q;
	logic          received_q;
	logic          out_valid_q;
	logic          clr;

	pix_t pix_q;
	pix_t win_q [9];
	pix_t up_rd, mid_rd;
	logic [PIX_BITS-1:0] up_rdata, mid_rdata;

	logic [SUM_W-1:0] sum_r, sum_g, sum_b;
	logic [1:0]       rows_n, cols_n;
	logic [2:0]       row_ok, col_ok;

	logic [SUM_W-1:0] sum_r_s1, sum_g_s1, sum_b_s1;
	logic [CNT_W-1:0] n_s1;
	logic             fe_s1;
	pix_t             out_pix_q;
	logic             out_last_q;

	assign w_last   = CW'(eff_w - WIDTH_REG_W'(1));
	assign h_last   = RW'(eff_h - HEIGHT_REG_W'(1));
	assign d_target = DW'(eff_w) + DW'(1);

	assign stat.received = received_q;
	assign stat.emit     = (d_q == d_target);
	assign stat.out_busy = out_valid_q && !m_tready;

	assign clr = cfg_clear || (cmd.load_out && fe_s1);

	bb3ea_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (cmd.shift),
		.waddr (in_col_q),
		.wdata (mid_rdata),
		.raddr (in_col_q),
		.rdata (up_rdata)
	);

	bb3ea_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (cmd.shift),
		.waddr (in_col_q),
		.wdata (pix_q),
		.raddr (in_col_q),
		.rdata (mid_rdata)
	);

	assign up_rd  = pix_t'(up_rdata);
	assign mid_rd = pix_t'(mid_rdata);

	// frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			d_q        <= '0;
			received_q <= 1'b0;
		end else if (clr) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			d_q        <= '0;
			received_q <= 1'b0;
		end else begin
			if (cmd.shift) begin
				if (in_col_q == w_last) begin
					in_col_q <= '0;
					if (!received_q) begin
						if (in_row_q == h_last) begin
							received_q <= 1'b1;
						end else begin
							in_row_q <= in_row_q + RW'(1);
						end
					end
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
				if (!stat.emit) begin
					d_q <= d_q + DW'(1);
				end
			end
			if (cmd.load_out) begin
				if (out_col_q == w_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + RW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	// pixel latch and window; columns move left, newest enters on the right
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pix_q <= received_q ? pix_t'('0) : pix_t'(s_tdata);
		end
		if (cmd.shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]     <= win_q[r*3 + 1];
				win_q[r*3 + 1] <= win_q[r*3 + 2];
			end
			win_q[2] <= up_rd;
			win_q[5] <= mid_rd;
			win_q[8] <= pix_q;
		end
	end

	// neighbourhood sums over the in-frame part of the window
	always_comb begin
		row_ok = {out_row_q != h_last, 1'b1, out_row_q != '0};
		col_ok = {out_col_q != w_last, 1'b1, out_col_q != '0};
		rows_n = 2'(row_ok[0]) + 2'(row_ok[1]) + 2'(row_ok[2]);
		cols_n = 2'(col_ok[0]) + 2'(col_ok[1]) + 2'(col_ok[2]);
		sum_r  = '0;
		sum_g  = '0;
		sum_b  = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (row_ok[r] && col_ok[c]) begin
					sum_r = sum_r + SUM_W'(win_q[r*3 + c].red);
					sum_g = sum_g + SUM_W'(win_q[r*3 + c].green);
					sum_b = sum_b + SUM_W'(win_q[r*3 + c].blue);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			sum_r_s1 <= sum_r;
			sum_g_s1 <= sum_g;
			sum_b_s1 <= sum_b;
			n_s1     <= {2'b00, rows_n} * {2'b00, cols_n};
			fe_s1    <= (out_row_q == h_last) && (out_col_q == w_last);
		end
		if (cmd.load_out) begin
			out_pix_q.red   <= chan_mean(sum_r_s1, n_s1);
			out_pix_q.green <= chan_mean(sum_g_s1, n_s1);
			out_pix_q.blue  <= chan_mean(sum_b_s1, n_s1);
			out_last_q      <= fe_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pix_q;
	assign m_tlast  = out_last_q;

	`BB_ASSERT_NOW(a_lag_bound, clk, arst_n, 1'b1, d_q <= d_target)
	`BB_ASSERT_NOW(a_out_row_bound, clk, arst_n, 1'b1, out_row_q <= h_last)
	`BB_ASSERT_NEXT(a_frame_end_clear, clk, arst_n, cmd.load_out && fe_s1,
		d_q == '0 && !received_q && in_col_q == '0)

endmodule
`default_nettype wire

>>> rtl/box_blur_3x3_edge_aware.sv
// Top level: APB registers, size clamping, controller and datapath.
//
// channel   dir  handshake            payload
// s_axis    in   tvalid/tready        tdata red,green,blue; tuser action (1 = drain)
// m_axis    out  tvalid/tready        tdata red,green,blue; tlast frame end
// apb       in   psel/penable/pready  frame_width @0x0, frame_height @0x4
//
// A pixel that gives no result passes accept and shift; one that gives a result also sum and divide.
// A drain after the frame is in steps like a pixel; one that comes early is taken and dropped.
// Accept, shift, sum and divide are a state each; a one-row double step adds a line store read.
// The output register lets the next item in while a result waits; a held result
// stalls the block only when the next result is ready to be loaded.
// Reset and any register write restart the frame; line stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module box_blur_3x3_edge_aware
	import bb3ea_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [PIX_BITS-1:0]   s_axis_tdata,  // red, green, blue
	input  wire logic                  s_axis_tuser,  // action
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [PIX_BITS-1:0]        m_axis_tdata,  // red, green, blue
	output logic                       m_axis_tlast,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	logic [WIDTH_REG_W-1:0]  width_q, eff_w;
	logic [HEIGHT_REG_W-1:0] height_q, eff_h;
	logic                    cfg_wr;
	cmd_t                    cmd;
	stat_t                   stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_FRAME_WIDTH:  width_q  <= pwdata[WIDTH_REG_W-1:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_q);
			REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		if (width_q == '0) begin
			eff_w = WIDTH_REG_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = WIDTH_REG_W'(MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		if (height_q == '0) begin
			eff_h = HEIGHT_REG_W'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = HEIGHT_REG_W'(MAX_HEIGHT);
		end else begin
			eff_h = height_q;
		end
	end

	bb3ea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_action (s_axis_tuser),
		.s_tready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bb3ea_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.cfg_clear (cfg_wr),
		.s_tdata   (s_axis_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tready  (m_axis_tready),
		.m_tvalid  (m_axis_tvalid),
		.m_tdata   (m_axis_tdata),
		.m_tlast   (m_axis_tlast)
	);

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the 3x3 edge-aware box blur: predictor, APB setup, random frames.
`timescale 1ns / 1ps
module testbench;
	import bb3ea_pkg::*;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;
	localparam int RANDOM_ITEMS = 600;
	localparam int QUIET_TAIL = 150;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		pix_t px;
		logic last;
	} blur_result_t;

	typedef enum logic [1:0] {ROW_SET_WIDTH, ROW_SET_HEIGHT, ROW_ITEM} row_kind_t;
	typedef enum logic [1:0] {FILL_RANDOM, FILL_EXTREME, FILL_FLAT} fill_t;

	typedef struct {
		row_kind_t kind;
		logic act;
		pix_t px;
		logic [APB_DATA_W-1:0] value;
		bit typed;
		blur_result_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [PIX_BITS-1:0] s_axis_tdata;  // red, green, blue
	logic s_axis_tuser;                 // action
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [PIX_BITS-1:0] m_axis_tdata;  // red, green, blue
	logic m_axis_tlast;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	// predictor state
	pix_t upper_rows [MAX_WIDTH_DEF];
	pix_t middle_rows [MAX_WIDTH_DEF];
	pix_t win [9];
	int unsigned pred_col, pred_row, pred_out;
	logic [WIDTH_REG_W-1:0] width_reg = WIDTH_RESET;
	logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;

	blur_result_t pending_blurs[$];
	int errors = 0;
	int items_fed = 0;
	int results_seen = 0;
	int frames_done = 0;
	int frames_cut = 0;
	int reg_writes = 0;
	int stall_cycles = 0;
	int unsigned idle_pct = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	box_blur_3x3_edge_aware dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned eff_width();
		if (width_reg == 0)
			return 1;
		return (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg == 0)
			return 1;
		return (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_reg;
	endfunction

	function automatic void blur_clear();
		int i;
		for (i = 0; i < 9; i++)
			win[i] = '0;
		pred_col = 0;
		pred_row = 0;
		pred_out = 0;
	endfunction

	function automatic void blur_shift(input pix_t px, input int unsigned w);
		int unsigned c;
		int r;
		pix_t up, mid;
		c = (pred_col < MAX_WIDTH_DEF) ? pred_col : 0;
		up = upper_rows[c];
		mid = middle_rows[c];
		for (r = 0; r < 3; r++) begin
			win[r * 3] = win[r * 3 + 1];
			win[r * 3 + 1] = win[r * 3 + 2];
		end
		win[2] = up;
		win[5] = mid;
		win[8] = px;
		upper_rows[c] = mid;
		middle_rows[c] = px;
		pred_col++;
		if (pred_col >= w) begin
			pred_col = 0;
			pred_row++;
		end
	endfunction

	// mean over the in-frame part of the window, rounded half up
	function automatic blur_result_t blur_mean(input int unsigned w, input int unsigned h);
		int unsigned ro, co, n, sr, sg, sb;
		int r, c;
		blur_result_t res;
		ro = pred_out / w;
		co = pred_out % w;
		n = 0;
		sr = 0;
		sg = 0;
		sb = 0;
		for (r = 0; r < 3; r++) begin
			if ((r == 0 && ro == 0) || (r == 2 && ro + 1 >= h))
				continue;
			for (c = 0; c < 3; c++) begin
				if ((c == 0 && co == 0) || (c == 2 && co + 1 >= w))
					continue;
				sr += win[r * 3 + c].red;
				sg += win[r * 3 + c].green;
				sb += win[r * 3 + c].blue;
				n++;
			end
		end
		res.px.red = 8'((sr + n / 2) / n);
		res.px.green = 8'((sg + n / 2) / n);
		res.px.blue = 8'((sb + n / 2) / n);
		pred_out++;
		res.last = (pred_out >= w * h);
		if (res.last)
			blur_clear();
		return res;
	endfunction

	function automatic bit blur_step(input logic act, input pix_t px, output blur_result_t res);
		int unsigned w, h, p;
		int k;
		w = eff_width();
		h = eff_height();
		res = '0;
		if (pred_row < h) begin
			if (act == ACT_DRAIN)
				return 1'b0;
			p = pred_row * w + pred_col;
			blur_shift(px, w);
			if (p >= pred_out + w + 1) begin
				res = blur_mean(w, h);
				return 1'b1;
			end
			return 1'b0;
		end
		// frame complete: pixels count as drains, a one-row frame steps twice
		for (k = 0; k < 3; k++) begin
			p = pred_row * w + pred_col;
			blur_shift('0, w);
			if (p >= pred_out + w + 1) begin
				res = blur_mean(w, h);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic apb_access(input logic wr, input logic idx, input logic [APB_DATA_W-1:0] wdata,
			output logic [APB_DATA_W-1:0] rdata);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = {idx, 2'b00};
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		@(negedge clk);
	endtask

	task automatic check_register(input logic idx, input logic [APB_DATA_W-1:0] want);
		logic [APB_DATA_W-1:0] got;
		apb_access(1'b0, idx, '0, got);
		if (got !== want) begin
			errors++;
			$display("%0t: register %0d read back: expected %0d, got %0d", $time, idx, want, got);
		end
	endtask

	task automatic set_register(input logic idx, input logic [APB_DATA_W-1:0] value);
		logic [APB_DATA_W-1:0] unused;
		s_axis_tvalid = 1'b0;
		while (pending_blurs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		apb_access(1'b1, idx, value, unused);
		if (idx == REG_FRAME_WIDTH)
			width_reg = value[WIDTH_REG_W-1:0];
		else
			height_reg = value[HEIGHT_REG_W-1:0];
		blur_clear();
		reg_writes++;
		check_register(idx, value);
	endtask

	task automatic feed_item(input logic act, input pix_t px, input bit typed,
			input blur_result_t want, output bit ended);
		blur_result_t res;
		bit has;
		s_axis_tvalid = 1'b1;
		s_axis_tdata = px;
		s_axis_tuser = act;
		do @(posedge clk); while (!s_axis_tready);
		if (!(act == ACT_DRAIN && pred_row < eff_height()))
			items_fed++;
		has = blur_step(act, px, res);
		if (typed)
			pending_blurs.push_back(want);
		else if (has)
			pending_blurs.push_back(res);
		ended = typed ? want.last : (has && res.last);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid = 1'b0;
			s_axis_tdata = PIX_BITS'($urandom);
			s_axis_tuser = $urandom_range(0, 1);
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
	endtask

	// cut = pixels sent before the frame is dropped, 0 for a whole frame
	task automatic run_frame(input int unsigned cut, input int unsigned noise_pct);
		int unsigned total, i, extra;
		fill_t fill;
		pix_t px, flat;
		blur_result_t none;
		bit ended;
		total = eff_width() * eff_height();
		fill = fill_t'($urandom_range(0, 2));
		flat = pix_t'(PIX_BITS'($urandom));
		none = '0;
		ended = 1'b0;
		for (i = 0; i < total && (cut == 0 || i < cut); i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				feed_item(ACT_DRAIN, pix_t'(PIX_BITS'($urandom)), 1'b0, none, ended);
			case (fill)
				FILL_EXTREME: begin
					px.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					px.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				end
				FILL_FLAT: px = flat;
				default: px = pix_t'(PIX_BITS'($urandom));
			endcase
			feed_item(ACT_PIXEL, px, 1'b0, none, ended);
		end
		if (cut != 0 && cut < total) begin
			frames_cut++;
			return;
		end
		while (!ended)
			feed_item(($urandom_range(0, 4) == 0) ? ACT_PIXEL : ACT_DRAIN,
				pix_t'(PIX_BITS'($urandom)), 1'b0, none, ended);
		frames_done++;
		if (noise_pct != 0) begin
			extra = $urandom_range(0, 2);
			repeat (extra) feed_item(ACT_DRAIN, pix_t'(PIX_BITS'($urandom)), 1'b0, none, ended);
		end
	endtask

	function automatic dir_row_t cfg_row(input row_kind_t kind, input int unsigned value);
		dir_row_t row;
		row = '{kind: kind, act: ACT_PIXEL, px: '0, value: value, typed: 1'b0, want: '0};
		return row;
	endfunction

	function automatic dir_row_t item_row(input logic act, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		dir_row_t row;
		row = cfg_row(ROW_ITEM, 0);
		row.act = act;
		row.px.red = r;
		row.px.green = g;
		row.px.blue = b;
		return row;
	endfunction

	function automatic dir_row_t item_chk(input logic act, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic [7:0] er,
			input logic [7:0] eg, input logic [7:0] eb, input logic last);
		dir_row_t row;
		row = item_row(act, r, g, b);
		row.typed = 1'b1;
		row.want.px.red = er;
		row.want.px.green = eg;
		row.want.px.blue = eb;
		row.want.last = last;
		return row;
	endfunction

	initial begin : receiver
		int unsigned rx_gap;
		rx_gap = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				m_axis_tready = 1'b1;
			end else if (rx_gap != 0) begin
				m_axis_tready = 1'b0;
				rx_gap--;
			end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
				m_axis_tready = 1'b0;
				rx_gap = $urandom_range(0, 12);
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		blur_result_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.px = pix_t'(m_axis_tdata);
			got.last = m_axis_tlast;
			results_seen++;
			if (pending_blurs.size() == 0) begin
				errors++;
				$display("%0t: unexpected result r=%0d g=%0d b=%0d last=%0d", $time,
					got.px.red, got.px.green, got.px.blue, got.last);
			end else begin
				want = pending_blurs.pop_front();
				if (got.px.red !== want.px.red || got.px.green !== want.px.green ||
						got.px.blue !== want.px.blue || got.last !== want.last) begin
					errors++;
					$display("%0t: mismatch: expected r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
						$time, want.px.red, want.px.green, want.px.blue, want.last,
						got.px.red, got.px.green, got.px.blue, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("box_blur_3x3_edge_aware test failed");
			$finish;
		end
	end

	initial begin : stimulus
		dir_row_t dir_rows [30];
		int unsigned rand_start, frames, f, cut, total, noise, w, h, pick;
		bit ended;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ACT_PIXEL;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		foreach (upper_rows[i]) begin
			upper_rows[i] = '0;
			middle_rows[i] = '0;
		end
		blur_clear();

		dir_rows = '{
			cfg_row(ROW_SET_WIDTH, 2),
			cfg_row(ROW_SET_HEIGHT, 1),
			item_row(ACT_DRAIN, 255, 255, 255),                  // drain before frame is in
			item_row(ACT_PIXEL, 0, 255, 1),
			item_row(ACT_PIXEL, 1, 255, 0),
			item_chk(ACT_DRAIN, 0, 0, 0, 1, 255, 1, 0),          // one row: double step
			item_chk(ACT_PIXEL, 77, 77, 77, 1, 255, 1, 1),       // pixel after frame drains
			cfg_row(ROW_SET_WIDTH, 3),
			cfg_row(ROW_SET_HEIGHT, 3),
			item_row(ACT_PIXEL, 9, 200, 31),
			item_row(ACT_PIXEL, 255, 0, 128),
			item_row(ACT_PIXEL, 40, 41, 42),
			cfg_row(ROW_SET_HEIGHT, 3),                          // drops the part frame
			item_row(ACT_PIXEL, 255, 255, 255),
			item_row(ACT_PIXEL, 255, 255, 255),
			item_row(ACT_PIXEL, 255, 255, 255),
			item_row(ACT_PIXEL, 255, 255, 255),
			item_chk(ACT_PIXEL, 255, 255, 255, 255, 255, 255, 0),
			item_chk(ACT_PIXEL, 255, 255, 255, 255, 255, 255, 0),
			item_chk(ACT_PIXEL, 255, 255, 255, 255, 255, 255, 0),
			item_chk(ACT_PIXEL, 255, 255, 255, 255, 255, 255, 0),
			item_chk(ACT_PIXEL, 255, 255, 255, 255, 255, 255, 0),
			item_chk(ACT_DRAIN, 0, 0, 0, 255, 255, 255, 0),
			item_chk(ACT_DRAIN, 0, 0, 0, 255, 255, 255, 0),
			item_chk(ACT_DRAIN, 0, 0, 0, 255, 255, 255, 0),
			item_chk(ACT_DRAIN, 0, 0, 0, 255, 255, 255, 1),
			cfg_row(ROW_SET_WIDTH, 1),
			cfg_row(ROW_SET_HEIGHT, 1),
			item_row(ACT_PIXEL, 255, 0, 255),
			item_chk(ACT_DRAIN, 0, 0, 0, 255, 0, 255, 1)
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		check_register(REG_FRAME_WIDTH, WIDTH_RESET);
		check_register(REG_FRAME_HEIGHT, HEIGHT_RESET);

		idle_pct = 30;
		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_SET_WIDTH: set_register(REG_FRAME_WIDTH, dir_rows[i].value);
				ROW_SET_HEIGHT: set_register(REG_FRAME_HEIGHT, dir_rows[i].value);
				default: feed_item(dir_rows[i].act, dir_rows[i].px, dir_rows[i].typed,
					dir_rows[i].want, ended);
			endcase
		end

		// size extremes: clamped width and height on a frame dropped early, zero sizes
		idle_pct = 10;
		set_register(REG_FRAME_WIDTH, 1023);
		set_register(REG_FRAME_HEIGHT, 8191);
		run_frame(530, 0);
		set_register(REG_FRAME_WIDTH, 0);
		set_register(REG_FRAME_HEIGHT, 0);
		run_frame(0, 0);

		// long output stall while the sender keeps offering
		idle_pct = 0;
		set_register(REG_FRAME_WIDTH, 6);
		set_register(REG_FRAME_HEIGHT, 5);
		hold_req = 1'b1;
		run_frame(0, 0);

		rand_start = items_fed;
		while (items_fed - rand_start < RANDOM_ITEMS) begin
			if (items_fed - rand_start >= RANDOM_ITEMS - QUIET_TAIL)
				quiet = 1'b1;
			pick = $urandom_range(0, 2);
			idle_pct = quiet ? 0 : (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
			noise = $urandom_range(0, 1) ? 10 : 0;
			pick = $urandom_range(0, 99);
			w = (pick < 4) ? 0 : (pick < 75) ? $urandom_range(1, 8) : $urandom_range(9, 40);
			pick = $urandom_range(0, 99);
			h = (pick < 4) ? 0 : (pick < 85) ? $urandom_range(1, 5) : $urandom_range(6, 12);
			pick = $urandom_range(0, 4);
			if (pick != 4)
				set_register(REG_FRAME_WIDTH, w);
			if (pick != 3)
				set_register(REG_FRAME_HEIGHT, h);
			frames = $urandom_range(1, 3);
			for (f = 1; f <= frames; f++) begin
				total = eff_width() * eff_height();
				cut = 0;
				if (f == frames && total > 1 && $urandom_range(0, 99) < 15)
					cut = $urandom_range(1, total - 1);
				run_frame(cut, noise);
			end
		end

		s_axis_tvalid = 1'b0;
		while (pending_blurs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d frames to the end and dropped %0d part-way, %0d register writes.",
			frames_done, frames_cut, reg_writes);
		$display("Fed %0d pixels and drains, checked %0d blurred pixels, %0d errors.",
			items_fed, results_seen, errors);
		if (errors == 0)
			$display("box_blur_3x3_edge_aware test passed");
		else
			$display("box_blur_3x3_edge_aware test failed");
		$finish;
	end
endmodule

>>> files.f
+incdir+rtl
rtl/bb3ea_pkg.sv
rtl/bb3ea_ram.sv
rtl/bb3ea_ctrl.sv
rtl/bb3ea_dp.sv
rtl/box_blur_3x3_edge_aware.sv
tb/testbench.sv
